[hw/rtl/b64d_pkg.sv]
// Shared types, constants and functions of the base64 stream decoder.
// No dependencies; every other RTL file of the decoder but the checker imports this package.
package b64d_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3d;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;

  // Work handed from the front end to the back end: up to three bytes and
  // the frame-close information.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;
    logic            bad;
  } b64d_work_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
    b64d_sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= "A" && c <= "Z") begin
      r.value = 6'(c - 8'h41);
    end else if (c >= "a" && c <= "z") begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == "+") begin
      r.value = 6'd62;
    end else if (c == "/") begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [2:0][7:0] make_bytes(input logic [5:0] s0, input logic [5:0] s1,
                                                 input logic [5:0] s2, input logic [5:0] s3);
    logic [2:0][7:0] b;
    b[0] = {s0, s1[5:4]};
    b[1] = {s1[3:0], s2[5:2]};
    b[2] = {s2[1:0], s3};
    return b;
  endfunction

endpackage

[hw/rtl/b64d_front.sv]
// Front end of the base64 decoder: classifies characters, gathers sextets
// and forms work entries. Depends on b64d_pkg.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  output logic                push,
  output b64d_pkg::b64d_work_t push_data
);
  import b64d_pkg::*;

  logic [2:0][5:0] sbuf, sbuf_next;
  logic [1:0]      gcount, gcount_next;
  logic            stopped, stopped_next;
  logic            err, err_next;
  b64d_sextet_t    sx;

  always_comb begin
    sx           = sextet_of(in_char);
    sbuf_next    = sbuf;
    gcount_next  = gcount;
    stopped_next = stopped;
    err_next     = err;
    push_data    = '0;
    if (!stopped) begin
      if (in_char == CHAR_PAD) begin
        stopped_next = 1'b1;
      end else if (in_char == CHAR_CR || in_char == CHAR_LF) begin
        stopped_next = stopped;
      end else if (!sx.valid) begin
        err_next = 1'b1;
      end else if (gcount == 2'd3) begin
        push_data.bytes  = make_bytes(sbuf[0], sbuf[1], sbuf[2], sx.value);
        push_data.nbytes = 2'd3;
        gcount_next      = 2'd0;
      end else begin
        sbuf_next[gcount] = sx.value;
        gcount_next       = gcount + 2'd1;
      end
    end
    if (in_last && push_data.nbytes == 2'd0 && gcount_next >= 2'd2) begin
      push_data.bytes  = make_bytes(sbuf_next[0], sbuf_next[1],
                                    (gcount_next == 2'd3) ? sbuf_next[2] : 6'd0, 6'd0);
      push_data.nbytes = gcount_next - 2'd1;
    end
    push_data.last = in_last;
    push_data.bad  = in_last && err_next;
    push = accept && (in_last || push_data.nbytes != 2'd0);
    if (in_last) begin
      sbuf_next    = '0;
      gcount_next  = 2'd0;
      stopped_next = 1'b0;
      err_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf    <= '0;
      gcount  <= 2'd0;
      stopped <= 1'b0;
      err     <= 1'b0;
    end else if (accept) begin
      sbuf    <= sbuf_next;
      gcount  <= gcount_next;
      stopped <= stopped_next;
      err     <= err_next;
    end
  end

endmodule

[hw/rtl/b64d_queue.sv]
// Small register queue of work entries between front and back end.
// Depends on b64d_pkg for the entry type.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::b64d_work_t push_data,
  output logic                full,
  input  logic                pop,
  output b64d_pkg::b64d_work_t pop_data,
  output logic                empty
);
  import b64d_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64d_work_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/b64d_back.sv]
// Back end of the base64 decoder: unrolls work entries into one result per
// transfer behind an output register. Depends on b64d_pkg.
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  b64d_pkg::b64d_work_t head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic [1:0] nres;
  logic       final_res;
  logic       load;

  assign nres      = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
  assign final_res = (idx == nres - 2'd1);
  assign load      = !empty && (!m_tvalid || m_tready);
  assign pop       = load && final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_res ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= (head.nbytes != 2'd0) ? head.bytes[idx] : 8'd0;
      m_tuser[0] <= (head.nbytes != 2'd0);
      m_tuser[1] <= final_res && head.bad;
      m_tlast    <= final_res && head.last;
    end
  end

endmodule

[hw/rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder: front end, work queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Input channel s_*: one encoded character per transfer in s_tdata, with
// s_tlast on the final character of a frame. CR and LF are skipped, all
// characters from the first '=' to the frame end are ignored, and other
// characters outside the alphabet set a frame error.
// Output channel m_*: one result per transfer. m_tdata carries the byte,
// m_tuser[0] says the byte is valid, m_tuser[1] is the frame error flag on
// the frame's last result, and m_tlast closes the frame. A frame whose last
// character releases no byte ends with a result that has m_tuser[0] low.
// Throughput: one character per cycle while the queue is not full; the results of
// a character that releases three bytes are absorbed by the work queue.
// A taken character's work entry is written into the queue, and its results
// then pass through the output register before they are offered on m_*.
// Reset clears the decode state, the queue and the output valid flag.
// When the receiver stalls, the queue fills and then s_tready drops.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] out_valid, [1] bad_symbol
  output logic       m_tlast
);
  import b64d_pkg::*;

  b64d_work_t push_data, head;
  logic       push, full, pop, empty;

  assign s_tready = !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_data (push_data)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/b64d_checker.sv]
// Port-level checks of the base64 stream decoder, bound to the top level.
// Depends only on the top level's ports.
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // An error flag is only ever shown on the result that closes a frame.
  a_bad_only_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("error flag on a result that does not close the frame");

  // A result without a byte is always the frame's closing result.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
    else $error("result without data that does not close the frame");

  // Nothing is offered in the cycle right after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/testbench.sv]
// Self-checking testbench for base64_stream_decoder: directed and random frames
// against a built-in decode predictor. Depends on b64d_pkg and the decoder RTL.

typedef struct packed {
  logic [7:0] data;
  logic       valid;
  logic       bad;
  logic       last;
} decoded_t;

class decode_scoreboard;
  logic [5:0]  held_sextets[3];
  int unsigned held;
  bit          pad_seen;
  bit          bad_seen;
  decoded_t    pending[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    foreach (held_sextets[i]) held_sextets[i] = '0;
    held     = 0;
    pad_seen = 0;
    bad_seen = 0;
  endfunction

  function int sextet_value(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2b) return 62;
    if (c == 8'h2f) return 63;
    return -1;
  endfunction

  // Works out the results that one accepted character causes.
  function void note_input(logic [7:0] c, logic last);
    logic [23:0] word;
    int          nbytes;
    int          v;
    decoded_t    r;
    nbytes = 0;
    word = '0;
    if (!pad_seen) begin
      if (c == b64d_pkg::CHAR_PAD) begin
        pad_seen = 1;
      end else if (c != b64d_pkg::CHAR_CR && c != b64d_pkg::CHAR_LF) begin
        v = sextet_value(c);
        if (v < 0) begin
          bad_seen = 1;
        end else if (held == 3) begin
          word = {held_sextets[0], held_sextets[1], held_sextets[2], 6'(v)};
          nbytes = 3;
          held = 0;
        end else begin
          held_sextets[held] = 6'(v);
          held++;
        end
      end
    end
    if (last && nbytes == 0 && held >= 2) begin
      word = {held_sextets[0], held_sextets[1],
              (held == 3) ? held_sextets[2] : 6'd0, 6'd0};
      nbytes = held - 1;
    end
    for (int k = 0; k < nbytes; k++) begin
      r.data  = word[23 - 8 * k -: 8];
      r.valid = 1'b1;
      r.last  = last && (k == nbytes - 1);
      r.bad   = r.last && bad_seen;
      pending = {pending, r};
    end
    if (last) begin
      if (nbytes == 0) begin
        r = '{data: 8'h00, valid: 1'b0, bad: bad_seen, last: 1'b1};
        pending = {pending, r};
      end
      clear_frame();
    end
  endfunction

  function void check_result(decoded_t got);
    decoded_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: byte=%02h valid=%b bad=%b last=%b",
                 got.data, got.valid, got.bad, got.last);
      return;
    end
    want = pending.pop_front();
    if (got.data !== want.data || got.valid !== want.valid ||
        got.bad !== want.bad || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected byte=%02h valid=%b bad=%b last=%b, ",
                  "got byte=%02h valid=%b bad=%b last=%b"},
                 want.data, want.valid, want.bad, want.last,
                 got.data, got.valid, got.bad, got.last);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_CHARS = 270;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  decode_scoreboard sb = new();
  int unsigned      chars_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      quiet_cycles = 0;
  bit               long_hold = 0;

  base64_stream_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] alphabet_char(int unsigned idx);
    if (idx < 26) return 8'h41 + 8'(idx);
    if (idx < 52) return 8'h61 + 8'(idx - 26);
    if (idx < 62) return 8'h30 + 8'(idx - 52);
    return (idx == 62) ? 8'h2b : 8'h2f;
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(c, last);
    chars_sent++;
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], i == text.len() - 1);
  endtask

  task automatic send_random_frame();
    logic [7:0]  text[$];
    int unsigned kind;
    int unsigned groups;
    int unsigned tail;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                          : $urandom_range(0, 3);
      tail = $urandom_range(0, 3);
      repeat (groups * 4 + tail) text = {text, alphabet_char($urandom_range(0, 63))};
      if (tail >= 2 && $urandom_range(0, 1) == 1)
        repeat (4 - tail) text = {text, b64d_pkg::CHAR_PAD};
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 2) == 0)
          text.insert($urandom_range(0, text.size()),
                      $urandom_range(0, 1) ? b64d_pkg::CHAR_CR : b64d_pkg::CHAR_LF);
      end
    end else if (kind < 85) begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        case ($urandom_range(0, 7))
          0: text = {text, 8'($urandom_range(0, 255))};
          1: text = {text, b64d_pkg::CHAR_PAD};
          default: text = {text, alphabet_char($urandom_range(0, 63))};
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) text = {text, 8'($urandom_range(0, 255))};
    end
    if (text.size() == 0) text = {text, b64d_pkg::CHAR_LF};
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  // Receiver: switches at random among four stall habits, and once holds off for a long time.
  initial begin
    int unsigned mode;
    int unsigned phase;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end else begin
        if (phase % 50 == 0) mode = $urandom_range(0, 3);
        phase++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= (phase % 4 == 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{data: m_tdata, valid: m_tuser[0], bad: m_tuser[1], last: m_tlast});
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    bit hold_done;
    hold_done = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("TWFu");
    send_text("AZaz09+/");
    send_text("TWE=!");
    send_char(8'h54, 1'b0);
    send_char(b64d_pkg::CHAR_CR, 1'b0);
    send_char(8'h57, 1'b0);
    send_char(8'h45, 1'b0);
    send_char(b64d_pkg::CHAR_LF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h54, 1'b1);
    send_char(b64d_pkg::CHAR_PAD, 1'b1);
    send_text("TQ==");

    while (chars_sent < RANDOM_CHARS) begin
      if (!hold_done && chars_sent >= 130) begin
        long_hold = 1;
        hold_done = 1;
      end
      send_random_frame();
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
hw/rtl/b64d_checker.sv
tb/testbench.sv
